// ----- hw/rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search unit.
package stbs_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned DEF_STORE_DEPTH = 1024;
	localparam int unsigned DEF_VALUE_WIDTH = 32;

	// Fixed field widths
	localparam int unsigned IDX_W = 10;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned POS_W = 10;
	localparam int unsigned PRB_W = 4;
	localparam logic [PRB_W-1:0] PRB_MAX = '1;

	// Request codes
	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // write key into the store at index
		logic init;      // latch key, set bounds, read first midpoint
		logic step;      // compare read data, narrow bounds, read next midpoint
		logic out_load;  // move search result into the output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;     // active range is empty
		logic hit;       // current probe equals the key
		logic exhaust;   // range empty after this probe
	} dp_stat_t;

endpackage

// ----- hw/rtl/stbs_ctrl.sv -----
// Controller state machine for the sorted table binary search unit.
module stbs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               req_type,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output stbs_pkg::dp_cmd_t  cmd,
	input  stbs_pkg::dp_stat_t stat
);
	import stbs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   is_search;

	assign out_free  = !out_valid_q || !out_stall;
	assign is_search = (req_type == REQ_SEARCH);
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && is_search) begin
					state_d = stat.empty ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (stat.hit || stat.exhaust) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands and input handshake
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid && !is_search;
				cmd.init = in_valid && is_search;
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	// Output valid: set on result load, cleared once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/stbs_dp.sv -----
// Datapath for the sorted table binary search unit: store, bounds, probe compare.
module stbs_dp #(
	parameter int unsigned STORE_DEPTH = stbs_pkg::DEF_STORE_DEPTH,
	parameter int unsigned VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata,
	input  logic [stbs_pkg::IDX_W-1:0]        index,
	input  logic signed [stbs_pkg::KEY_W-1:0] key,
	input  stbs_pkg::dp_cmd_t                 cmd,
	output stbs_pkg::dp_stat_t                stat,
	output logic                              found,
	output logic [stbs_pkg::POS_W-1:0]        position,
	output logic [stbs_pkg::PRB_W-1:0]        probe_count
);
	import stbs_pkg::*;

	localparam int unsigned AW  = $clog2(STORE_DEPTH);
	localparam int unsigned CLW = $clog2(STORE_DEPTH + 1);
	localparam int unsigned CW  = (CLW > CNT_W) ? CLW : CNT_W;
	localparam int unsigned SW  = CW + 2;

	// Store
	logic [VALUE_WIDTH-1:0] mem [STORE_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;

	// Configuration and search state
	logic [CNT_W-1:0]       active_count_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic signed [CW:0]     left_q;
	logic signed [CW:0]     right_q;
	logic [AW-1:0]          mid_q;
	logic [PRB_W-1:0]       probes_q;
	logic                   hit_q;
	logic [POS_W-1:0]       pos_q;
	logic                   found_q;
	logic [POS_W-1:0]       position_q;
	logic [PRB_W-1:0]       probe_count_q;

	logic signed [63:0]     key_ext;
	logic [VALUE_WIDTH-1:0] key_norm;
	logic [CW-1:0]          act_ext;
	logic [CW-1:0]          n_w;
	logic [CW-1:0]          n_m1;
	logic [CW-1:0]          mid0_full;
	logic [AW-1:0]          mid0;
	logic                   index_ok;
	logic                   wr_en;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   eq;
	logic                   lt;
	logic signed [SW-1:0]   mid_ext;
	logic signed [SW-1:0]   left_ext;
	logic signed [SW-1:0]   right_ext;
	logic signed [SW-1:0]   up_left;
	logic signed [SW-1:0]   dn_right;
	logic signed [SW-1:0]   sum_w;
	logic signed [SW-1:0]   nmid;
	logic                   exhaust;
	logic [AW-1:0]          next_addr;

	// Key narrowed to the stored value width
	assign key_ext  = 64'(key);
	assign key_norm = key_ext[VALUE_WIDTH-1:0];

	// Active range clamped to the store depth
	assign act_ext   = CW'(active_count_q);
	assign n_w       = (act_ext > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : act_ext;
	assign n_m1      = n_w - CW'(1);
	assign mid0_full = n_m1 >> 1;
	assign mid0      = mid0_full[AW-1:0];

	// Probe compare on the word read for the current midpoint
	assign eq = (rd_data_q == key_q);
	assign lt = ($signed(rd_data_q) < $signed(key_q));

	// Candidate bounds and next midpoint
	assign mid_ext   = $signed({{(SW-AW){1'b0}}, mid_q});
	assign left_ext  = SW'(left_q);
	assign right_ext = SW'(right_q);
	assign up_left   = mid_ext + SW'(1);
	assign dn_right  = mid_ext - SW'(1);
	assign exhaust   = lt ? (up_left > right_ext) : (left_ext > dn_right);
	assign sum_w     = lt ? (up_left + right_ext) : (left_ext + dn_right);
	assign nmid      = sum_w >>> 1;
	assign next_addr = nmid[AW-1:0];

	assign stat.empty   = (n_w == '0);
	assign stat.hit     = eq;
	assign stat.exhaust = exhaust;

	// Store port control
	assign index_ok = (32'(index) < 32'(STORE_DEPTH));
	assign wr_en    = cmd.load && index_ok;
	assign rd_en    = cmd.init || cmd.step;
	assign rd_addr  = cmd.init ? mid0 : next_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(index)] <= key_norm;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
		end else if (cfg_we) begin
			active_count_q <= cfg_wdata;
		end
	end

	// Search bounds, probe count and match
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			key_q    <= key_norm;
			left_q   <= '0;
			right_q  <= (CW+1)'(n_w) - (CW+1)'(1);
			mid_q    <= mid0;
			probes_q <= '0;
			hit_q    <= 1'b0;
			pos_q    <= '0;
		end else if (cmd.step) begin
			if (probes_q != PRB_MAX) begin
				probes_q <= probes_q + PRB_W'(1);
			end
			if (eq) begin
				hit_q <= 1'b1;
				pos_q <= POS_W'(mid_q);
			end else begin
				if (lt) begin
					left_q <= up_left[CW:0];
				end else begin
					right_q <= dn_right[CW:0];
				end
				mid_q <= next_addr;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q       <= hit_q;
			position_q    <= pos_q;
			probe_count_q <= probes_q;
		end
	end

	assign found       = found_q;
	assign position    = position_q;
	assign probe_count = probe_count_q;

endmodule

// ----- hw/rtl/sorted_table_binary_search_unit.sv -----
// Sorted table binary search unit: top level joining controller and datapath.
//
// Input channel (in_valid/in_stall, fields req_type, index, key): a load
// (req_type 0) writes key into the store at index and gives no result; a
// search (req_type 1) looks for key among entries 0 .. active_count-1, which
// must be loaded and sorted ascending. Each search gives one result on the
// output channel (out_valid/out_stall): found, position, probe_count. The user
// must write active_count (cfg_we/cfg_wdata) only when idle; it is not checked.
//
// Timing: a load is taken without stalling. A search holds in_stall from its
// transfer until its result moves into the output register; the next item is
// taken once the unit is idle again. One probe per cycle is set by the single
// read port of the store (registered read); an empty table is not probed.
//
// Reset clears the controller, the output valid and active_count; the store
// is not cleared and an entry must be loaded before a search reads it.
// While the receiver stalls, the result holds in the output register and a
// finished search waits in its last state; loads are taken again only once
// the pending search has moved its result out.
module sorted_table_binary_search_unit #(
	parameter int unsigned STORE_DEPTH = stbs_pkg::DEF_STORE_DEPTH,
	parameter int unsigned VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stbs_pkg::CNT_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [stbs_pkg::IDX_W-1:0]        index,
	input  logic signed [stbs_pkg::KEY_W-1:0] key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [stbs_pkg::POS_W-1:0]        position,
	output logic [stbs_pkg::PRB_W-1:0]        probe_count
);
	import stbs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller
	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath
	stbs_dp #(
		.STORE_DEPTH (STORE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.index       (index),
		.key         (key),
		.cmd         (cmd),
		.stat        (stat),
		.found       (found),
		.position    (position),
		.probe_count (probe_count)
	);

	// A miss always reports position zero
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("miss result with nonzero position");

	// A hit needs at least one probe
	a_hit_probed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> probe_count != '0)
		else $error("hit result with zero probes");

	// A search transfer blocks the input channel in the next cycle
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type == REQ_SEARCH |=> in_stall)
		else $error("input taken while a search is running");

endmodule
